>>> design/urm_pkg.sv
// ----------------------------------------------------------------------------
// urm_pkg
// Shared types, constants and register codes of the ultrasonic ranging core.
// ----------------------------------------------------------------------------
package urm_pkg;

  // Width of the configuration registers and of the configuration data.
  localparam int REG_W = 12;
  localparam int IDX_W = 2;
  localparam int DIST_W = 13;

  localparam int COUNT_BITS_DEF = 12;

  localparam logic [REG_W-1:0] RISE_TIMEOUT_RST = 12'd2000;
  localparam logic [REG_W-1:0] MAX_ECHO_RST = 12'd3800;

  // Speed of sound in m/s; the echo covers the distance twice.
  localparam int SPEED_MPS = 346;
  localparam int MM_DIV = 100;

  // floor(count * 173 / 100) is taken as (count * SCALE_MUL) >> SCALE_SHIFT.
  // The rounding error stays below one part in a hundred for any 12-bit count.
  localparam int SCALE_SHIFT = 24;
  localparam int SCALE_MUL_W = 25;
  localparam logic [63:0] SCALE_MUL_64 =
      ((64'(SPEED_MPS) / 64'd2) * (64'd1 << SCALE_SHIFT) + 64'(MM_DIV) - 64'd1)
      / 64'(MM_DIV);
  localparam logic [SCALE_MUL_W-1:0] SCALE_MUL = SCALE_MUL_64[SCALE_MUL_W-1:0];

  typedef enum logic [IDX_W-1:0] {
    REG_RISE_TIMEOUT = 2'd0,
    REG_MAX_ECHO     = 2'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_t;

  // Per-tick outcome handed from the sequencer to the distance scaler.
  typedef struct packed {
    logic             trigger;
    logic             done;
    status_t          status;
    logic [REG_W-1:0] count_lo;
  } tick_res_t;

endpackage

>>> design/ultrasonic_range_measure_core.sv
// ----------------------------------------------------------------------------
// ultrasonic_range_measure_core
// HC-SR04 style ranging core, one input transaction per 10 us tick.
// ----------------------------------------------------------------------------
// Each input transaction is one tick carrying a start request and the sampled
// echo level; each one yields exactly one result transaction with the trigger
// level, a done flag, the distance in millimetres and a status code. The core
// takes one tick per clock cycle while the output is not stalled: a tick passes
// an input register, the sequencer and the distance multiplier, and is
// registered in the output register once that is free or emptying. The
// single constant multiply between the sequencer state and the output register
// sets the clock limit. Configuration writes are taken at any time on cfg_we
// and act on ticks processed afterwards.
module ultrasonic_range_measure_core import urm_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_start_req,
  input  logic              in_echo,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_trigger,
  output logic              out_done_res,
  output logic [DIST_W-1:0] out_distance_mm,
  output logic [1:0]        out_status,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [REG_W-1:0]  cfg_wdata
);

  logic [REG_W-1:0] rise_timeout_r;
  logic [REG_W-1:0] max_echo_r;

  logic in_valid_r;
  logic start_r;
  logic echo_r;
  logic advance;

  tick_res_t         res;
  logic [DIST_W-1:0] dist_mm;

  logic              out_valid_r;
  logic              trigger_r;
  logic              done_r;
  logic [DIST_W-1:0] dist_r;
  logic [1:0]        status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_timeout_r <= RISE_TIMEOUT_RST;
      max_echo_r     <= MAX_ECHO_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RISE_TIMEOUT: rise_timeout_r <= cfg_wdata;
        REG_MAX_ECHO:     max_echo_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The held tick moves on whenever the output register is free or emptying.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      start_r <= in_start_req;
      echo_r  <= in_echo;
    end
  end

  urm_ctrl #(
    .COUNT_BITS(COUNT_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance),
    .start_req     (start_r),
    .echo          (echo_r),
    .rise_timeout  (rise_timeout_r),
    .max_echo_ticks(max_echo_r),
    .res           (res)
  );

  urm_scale u_scale (
    .res        (res),
    .distance_mm(dist_mm)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      trigger_r <= res.trigger;
      done_r    <= res.done;
      dist_r    <= dist_mm;
      status_r  <= res.status;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_trigger     = trigger_r;
  assign out_done_res    = done_r;
  assign out_distance_mm = dist_r;
  assign out_status      = status_r;

  // A tick cannot both fire the trigger and complete a measurement.
  a_trig_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_trigger && out_done_res))
    else $error("trigger and done in the same result");

  // Distance and status are only nonzero on a completing tick.
  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res |-> out_distance_mm == '0 && out_status == ST_OK)
    else $error("result fields set without done");

  // An error status never carries a distance.
  a_err_no_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_distance_mm == '0)
    else $error("distance reported with error status");

  // A delivered result with nothing behind it leaves the output empty.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !advance |=> !out_valid)
    else $error("result repeated after delivery");

endmodule

>>> design/urm_ctrl.sv
// ----------------------------------------------------------------------------
// urm_ctrl
// Measurement sequencer: trigger, wait for echo rise, count echo ticks.
// ----------------------------------------------------------------------------
module urm_ctrl import urm_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             start_req,
  input  logic             echo,
  input  logic [REG_W-1:0] rise_timeout,
  input  logic [REG_W-1:0] max_echo_ticks,
  output tick_res_t        res
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_MEAS = 2'd2
  } phase_t;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  phase_t                phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] rise_cnt_r, rise_cnt_nxt;
  logic [COUNT_BITS-1:0] echo_cnt_r, echo_cnt_nxt;
  logic                  timed_out_r, timed_out_nxt;

  always_comb begin
    phase_nxt     = phase_r;
    rise_cnt_nxt  = rise_cnt_r;
    echo_cnt_nxt  = echo_cnt_r;
    timed_out_nxt = timed_out_r;
    res           = '0;
    res.status    = ST_OK;
    res.count_lo  = echo_cnt_r[REG_W-1:0];
    unique case (phase_r)
      PH_WAIT: begin
        if (echo) begin
          phase_nxt     = PH_MEAS;
          echo_cnt_nxt  = COUNT_BITS'(1);
          timed_out_nxt = 1'b0;
        end else if (rise_cnt_r >= COUNT_BITS'(rise_timeout)) begin
          // Give up on the rise and measure anyway; the result reports it.
          phase_nxt     = PH_MEAS;
          echo_cnt_nxt  = '0;
          timed_out_nxt = 1'b1;
        end else if (rise_cnt_r != CNT_MAX) begin
          rise_cnt_nxt = rise_cnt_r + COUNT_BITS'(1);
        end
      end
      PH_MEAS: begin
        if (echo) begin
          if (echo_cnt_r != CNT_MAX) begin
            echo_cnt_nxt = echo_cnt_r + COUNT_BITS'(1);
          end
        end else begin
          res.done  = 1'b1;
          phase_nxt = PH_IDLE;
          if (timed_out_r) begin
            res.status = ST_TIMEOUT;
          end else if (echo_cnt_r >= COUNT_BITS'(max_echo_ticks)) begin
            res.status = ST_RANGE;
          end
        end
      end
      default: begin
        // Idle, and the unused phase code, which behaves as idle.
        phase_nxt = PH_IDLE;
        if (start_req) begin
          res.trigger  = 1'b1;
          rise_cnt_nxt = '0;
          phase_nxt    = PH_WAIT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      rise_cnt_r  <= '0;
      echo_cnt_r  <= '0;
      timed_out_r <= 1'b0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      rise_cnt_r  <= rise_cnt_nxt;
      echo_cnt_r  <= echo_cnt_nxt;
      timed_out_r <= timed_out_nxt;
    end
  end

endmodule

>>> design/urm_scale.sv
// ----------------------------------------------------------------------------
// urm_scale
// Converts an echo length in ticks into millimetres by a constant multiply.
// ----------------------------------------------------------------------------
module urm_scale import urm_pkg::*; (
  input  tick_res_t         res,
  output logic [DIST_W-1:0] distance_mm
);

  localparam int PROD_W = REG_W + SCALE_MUL_W;

  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(res.count_lo) * PROD_W'(SCALE_MUL);

  // Only a completed, in-range measurement carries a distance.
  assign distance_mm = (res.done && res.status == ST_OK)
                       ? prod[SCALE_SHIFT +: DIST_W] : '0;

endmodule

>>> dv/ultrasonic_range_measure_core_tb.sv
// ----------------------------------------------------------------------------
// ultrasonic_range_measure_core_tb
// Self-checking testbench for the ultrasonic ranging core.
// ----------------------------------------------------------------------------
// Ticks are sent over the input handshake as directed sequences and as random
// echo pulses mixed with noise. A behavioral model of the ranging sequencer
// runs alongside and queues the reading that each accepted tick should give.
// Every result transaction is compared field by field with the oldest queued
// reading. Sender gaps and receiver stalls are varied from phase to phase.
module ultrasonic_range_measure_core_tb;
  import urm_pkg::*;

  localparam int CNT_W = COUNT_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam logic [REG_W-1:0] REG_MAX_VAL = '1;

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'd0,
    SEQ_WAIT = 2'd1,
    SEQ_MEAS = 2'd2
  } seq_phase_t;

  typedef struct packed {
    logic              trigger;
    logic              done;
    logic [DIST_W-1:0] distance;
    status_t           status;
  } reading_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_start_req;
  logic              in_echo;
  logic              out_valid;
  logic              out_ready;
  logic              out_trigger;
  logic              out_done_res;
  logic [DIST_W-1:0] out_distance_mm;
  logic [1:0]        out_status;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [REG_W-1:0]  cfg_wdata;

  // Model state of the sequencer and its registers.
  seq_phase_t       mdl_phase;
  logic [CNT_W-1:0] mdl_rise_cnt;
  logic [CNT_W-1:0] mdl_echo_cnt;
  logic             mdl_timed_out;
  logic [REG_W-1:0] mdl_rise_timeout;
  logic [REG_W-1:0] mdl_max_echo;

  reading_t pending_readings[$];
  int mismatches = 0;
  int readings_seen = 0;
  int pulse_ticks = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  ultrasonic_range_measure_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_start_req    (in_start_req),
    .in_echo         (in_echo),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_trigger     (out_trigger),
    .out_done_res    (out_done_res),
    .out_distance_mm (out_distance_mm),
    .out_status      (out_status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Advances the model by one tick and returns the reading it produces.
  function automatic reading_t next_reading(input logic start, input logic echo);
    reading_t r;
    int mm;
    r = '0;
    r.status = ST_OK;
    case (mdl_phase)
      SEQ_WAIT: begin
        if (echo) begin
          mdl_phase = SEQ_MEAS;
          mdl_echo_cnt = CNT_W'(1);
          mdl_timed_out = 1'b0;
        end else if (mdl_rise_cnt >= mdl_rise_timeout) begin
          mdl_phase = SEQ_MEAS;
          mdl_echo_cnt = '0;
          mdl_timed_out = 1'b1;
        end else begin
          mdl_rise_cnt = sat_inc(mdl_rise_cnt);
        end
      end
      SEQ_MEAS: begin
        if (echo) begin
          mdl_echo_cnt = sat_inc(mdl_echo_cnt);
        end else begin
          r.done = 1'b1;
          if (mdl_timed_out) begin
            r.status = ST_TIMEOUT;
          end else if (mdl_echo_cnt >= mdl_max_echo) begin
            r.status = ST_RANGE;
          end else begin
            // Round trip at the speed of sound, scaled to millimetres per tick.
            mm = int'(mdl_echo_cnt) * SPEED_MPS / 2 / MM_DIV;
            r.distance = DIST_W'(mm);
          end
          mdl_phase = SEQ_IDLE;
        end
      end
      default: begin
        mdl_phase = SEQ_IDLE;
        if (start) begin
          r.trigger = 1'b1;
          mdl_rise_cnt = '0;
          mdl_phase = SEQ_WAIT;
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on reading %0d, %s: got %0d, want %0d", readings_seen, what, got,
             want);
    mismatches++;
  endtask

  task automatic send_tick(input logic start, input logic echo);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_req <= start;
    in_echo <= echo;
    do @(posedge clk); while (!in_ready);
    pending_readings.push_back(next_reading(start, echo));
  endtask

  // One measurement: trigger tick, low ticks while waiting, the echo pulse and
  // the falling tick. Starts on the busy ticks are either forced or random.
  task automatic send_pulse(input int gap, input int len, input bit busy_start);
    send_tick(1'b1, 1'($urandom_range(1)));
    repeat (gap) send_tick(busy_start | 1'($urandom_range(1)), 1'b0);
    repeat (len) send_tick(busy_start | 1'($urandom_range(1)), 1'b1);
    send_tick(busy_start | 1'($urandom_range(1)), 1'b0);
    pulse_ticks += gap + len + 2;
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    wait_results_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_RISE_TIMEOUT: mdl_rise_timeout = val;
      REG_MAX_ECHO:     mdl_max_echo = val;
      default: ;
    endcase
  endtask

  task automatic test_reset_defaults();
    send_idle_pct = 25;
    recv_stall_pct = 25;
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_pulse(0, 1, 1'b0);
    send_pulse(3, 5, 1'b0);
    // Requests while busy, the completing tick included, must be ignored.
    send_pulse(2, 4, 1'b1);
  endtask

  task automatic test_rise_timeout();
    write_reg(REG_RISE_TIMEOUT, '0);
    send_pulse(1, 0, 1'b0);
    // A late echo after the timeout still reports a timeout.
    send_pulse(2, 3, 1'b0);
    write_reg(REG_RISE_TIMEOUT, 12'd3);
    send_pulse(3, 2, 1'b0);
    send_pulse(4, 2, 1'b0);
  endtask

  task automatic test_max_echo();
    write_reg(REG_MAX_ECHO, '0);
    send_pulse(0, 1, 1'b0);
    write_reg(REG_MAX_ECHO, 12'd3);
    send_pulse(0, 2, 1'b0);
    send_pulse(0, 3, 1'b0);
  endtask

  task automatic test_spare_index();
    write_reg(REG_SPARE_A, REG_W'($urandom));
    write_reg(REG_SPARE_B, REG_W'($urandom));
    send_pulse(0, 2, 1'b0);
    send_pulse(0, 3, 1'b0);
  endtask

  task automatic test_counter_limits();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(REG_RISE_TIMEOUT, 12'd40);
    write_reg(REG_MAX_ECHO, 12'd50);
    // Rise on the very tick the timeout is due, which the echo wins, then the timeout itself.
    send_pulse(40, 45, 1'b0);
    send_pulse(41, 0, 1'b0);
    // Echo lengths just below and at the range limit.
    send_pulse(0, 49, 1'b0);
    send_pulse(0, 50, 1'b0);
  endtask

  task automatic pick_random_config();
    int sel;
    sel = $urandom_range(5);
    write_reg(REG_RISE_TIMEOUT, (sel == 0) ? '0 : (sel == 1) ? REG_MAX_VAL :
              REG_W'($urandom_range(0, 30)));
    sel = $urandom_range(5);
    write_reg(REG_MAX_ECHO, (sel == 0) ? '0 : (sel == 1) ? REG_MAX_VAL :
              REG_W'($urandom_range(0, 40)));
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall_pct, input int n_ticks);
    int first;
    int gap_hi;
    int len_hi;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    first = pulse_ticks;
    pick_random_config();
    while (pulse_ticks - first < n_ticks) begin
      if ($urandom_range(19) == 0) begin
        pick_random_config();
      end else if ($urandom_range(19) == 0) begin
        wait_results_drained();
      end
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        gap_hi = (int'(mdl_rise_timeout) + 2 > 30) ? 30 : int'(mdl_rise_timeout) + 2;
        len_hi = (int'(mdl_max_echo) + 3 > 40) ? 40 : int'(mdl_max_echo) + 3;
        send_pulse($urandom_range(0, gap_hi), $urandom_range(1, len_hi), 1'b0);
      end
    end
  endtask

  // Result checker; also draws the receiver's ready for the next cycle.
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("result with no reading pending", 1, 0);
      end else begin
        want = pending_readings.pop_front();
        if (out_trigger !== want.trigger)
          report_mismatch("trigger", out_trigger, want.trigger);
        if (out_done_res !== want.done)
          report_mismatch("done_res", out_done_res, want.done);
        if (out_distance_mm !== want.distance)
          report_mismatch("distance_mm", out_distance_mm, want.distance);
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
      end
      readings_seen++;
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction in %0d cycles", WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_start_req <= 1'b0;
    in_echo <= 1'b0;
    out_ready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    mdl_phase = SEQ_IDLE;
    mdl_rise_cnt = '0;
    mdl_echo_cnt = '0;
    mdl_timed_out = 1'b0;
    mdl_rise_timeout = RISE_TIMEOUT_RST;
    mdl_max_echo = MAX_ECHO_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_rise_timeout();
    test_max_echo();
    test_spare_index();
    test_counter_limits();
    run_random_phase(0, 0, 310);
    run_random_phase(64, 0, 310);
    run_random_phase(0, 64, 310);
    run_random_phase(25, 25, 310);

    wait_results_drained();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
